[rtl/pst_pkg.sv]
// Package for the spanning tree engine: request and status codes, limits,
// and the control group sent from the sequencer to the vertex cells.
// No dependencies.
package pst_pkg;

  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_TOTAL = 2'd1;
  localparam logic [1:0] REQ_EDGES = 2'd2;

  localparam logic [1:0] ST_EDGE     = 2'd0;
  localparam logic [1:0] ST_TOTAL    = 2'd1;
  localparam logic [1:0] ST_BAD_START = 2'd2;
  localparam logic [1:0] ST_NO_EDGES = 2'd3;

  localparam logic [19:0] SUM_MAX   = 20'hFFFFF;
  localparam logic [3:0]  MAX_OUT   = 4'd15;
  localparam logic [4:0]  NV_RESET  = 5'd16;

  typedef struct packed {
    logic init;  // start of run: clear candidates, mark start vertex
    logic upd;   // offer edges out of the newest tree vertex
    logic take;  // vertex on vtx joins the tree
  } cell_ctrl_t;

endpackage

[rtl/pst_cell.sv]
// One vertex cell: holds the matrix column of its vertex, its visited flag and
// best candidate edge, and passes the running minimum on to the next cell.
// Depends on pst_pkg.
module pst_cell #(
  parameter int MAX_V = 16,
  parameter int WB    = 16,
  parameter int IDX   = 0
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  pst_pkg::cell_ctrl_t        ctrl,
  input  logic [$clog2(MAX_V)-1:0]   vtx,
  input  logic [$clog2(MAX_V)-1:0]   rank,
  input  logic [$clog2(MAX_V+1)-1:0] n_act,
  input  logic                       wr_en,
  input  logic [$clog2(MAX_V)-1:0]   wr_row,
  input  logic [$clog2(MAX_V)-1:0]   wr_col,
  input  logic [WB-1:0]              wr_data,
  input  logic                       cin_vld,
  input  logic [WB-1:0]              cin_w,
  input  logic [$clog2(MAX_V)-1:0]   cin_rank,
  input  logic [$clog2(MAX_V)-1:0]   cin_par,
  input  logic [$clog2(MAX_V)-1:0]   cin_child,
  output logic                       cout_vld,
  output logic [WB-1:0]              cout_w,
  output logic [$clog2(MAX_V)-1:0]   cout_rank,
  output logic [$clog2(MAX_V)-1:0]   cout_par,
  output logic [$clog2(MAX_V)-1:0]   cout_child
);

  localparam int VB = $clog2(MAX_V);
  localparam logic [VB-1:0] MY_IDX = VB'(IDX);

  logic [WB-1:0] mem [MAX_V];
  logic [MAX_V-1:0] wvld_r;
  logic [WB-1:0] rd_w_r;

  logic          visited_r, visited_nxt;
  logic          bvld_r, bvld_nxt;
  logic [WB-1:0] bw_r, bw_nxt;
  logic [VB-1:0] brank_r, brank_nxt;
  logic [VB-1:0] bpar_r, bpar_nxt;
  logic          active;
  logic          own_wins;

  assign active = (32'(IDX) < 32'(n_act));

  always_ff @(posedge clk) begin
    if (wr_en && wr_col == MY_IDX) begin
      mem[wr_row] <= wr_data;
    end
    rd_w_r <= wvld_r[vtx] ? mem[vtx] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wvld_r <= '0;
    end else if (wr_en && wr_col == MY_IDX) begin
      wvld_r[wr_row] <= 1'b1;
    end
  end

  always_comb begin
    visited_nxt = visited_r;
    bvld_nxt    = bvld_r;
    bw_nxt      = bw_r;
    brank_nxt   = brank_r;
    bpar_nxt    = bpar_r;
    if (ctrl.init) begin
      visited_nxt = (vtx == MY_IDX);
      bvld_nxt    = 1'b0;
    end else if (ctrl.take && vtx == MY_IDX) begin
      visited_nxt = 1'b1;
      bvld_nxt    = 1'b0;
    end else if (ctrl.upd && active && !visited_r && rd_w_r != '0 &&
                 (!bvld_r || rd_w_r < bw_r)) begin
      // strictly lower weight only: an older queued edge wins ties
      bvld_nxt  = 1'b1;
      bw_nxt    = rd_w_r;
      brank_nxt = rank;
      bpar_nxt  = vtx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      visited_r <= 1'b0;
      bvld_r    <= 1'b0;
    end else begin
      visited_r <= visited_nxt;
      bvld_r    <= bvld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bw_r    <= bw_nxt;
    brank_r <= brank_nxt;
    bpar_r  <= bpar_nxt;
  end

  // key order: weight, then parent's join rank, then child index
  assign own_wins = bvld_r && (!cin_vld || bw_r < cin_w ||
                               (bw_r == cin_w && brank_r < cin_rank));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cout_vld <= 1'b0;
    end else begin
      cout_vld <= cin_vld || bvld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (own_wins) begin
      cout_w     <= bw_r;
      cout_rank  <= brank_r;
      cout_par   <= bpar_r;
      cout_child <= MY_IDX;
    end else begin
      cout_w     <= cin_w;
      cout_rank  <= cin_rank;
      cout_par   <= cin_par;
      cout_child <= cin_child;
    end
  end

endmodule

[rtl/prim_spanning_tree_engine_top.sv]
// Minimum spanning tree engine, Prim's method over a chain of vertex cells.
// Load: one per cycle while idle, busy stays low. Run: per tree edge a matrix
// row read, a candidate update, a minimum sweep down the cell chain and a
// decision; runs hold busy high. Results are one-cycle strobes.
// Synchronous active-low reset clears the matrix (per-entry valid bits) and
// sets num_vertices to 16; no clearing pass is needed.
module prim_spanning_tree_engine_top #(
  parameter int MAX_VERTICES = 16,
  parameter int WEIGHT_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_req_type,
  input  logic [3:0]  in_row,
  input  logic [3:0]  in_col,
  input  logic [15:0] in_weight,
  input  logic [5:0]  in_start_vertex,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [3:0]  out_parent_vertex,
  output logic [3:0]  out_child_vertex,
  output logic [19:0] out_total_weight,
  output logic        out_last
);

  localparam int VB = $clog2(MAX_VERTICES);
  localparam int NB = $clog2(MAX_VERTICES + 1);
  localparam int WB = WEIGHT_BITS;
  localparam logic [VB-1:0] SWEEP_LAST = VB'(MAX_VERTICES - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_INIT   = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_EXP    = 3'd3;
  localparam logic [2:0] S_SWEEP  = 3'd4;
  localparam logic [2:0] S_DECIDE = 3'd5;

  logic [2:0]    state_r, state_nxt;
  logic [4:0]    nv_r;
  logic [NB-1:0] n_eff;
  logic [VB-1:0] cur_r, cur_nxt;
  logic [VB-1:0] rank_r, rank_nxt;
  logic [VB-1:0] sweep_r, sweep_nxt;
  logic          edge_run_r, edge_run_nxt;
  logic [19:0]   sum_r, sum_nxt;
  logic [3:0]    ecnt_r, ecnt_nxt;
  logic [3:0]    pend_par_r, pend_par_nxt;
  logic [3:0]    pend_child_r, pend_child_nxt;

  logic          ov_nxt;
  logic [1:0]    ost_nxt;
  logic [3:0]    opar_nxt, ochild_nxt;
  logic [19:0]   otw_nxt;
  logic          olast_nxt;

  pst_pkg::cell_ctrl_t ctrl;
  logic [VB-1:0] vtx;
  logic          load_ok;
  logic [WB-1:0] wr_data;

  logic          c_vld   [MAX_VERTICES+1];
  logic [WB-1:0] c_w     [MAX_VERTICES+1];
  logic [VB-1:0] c_rank  [MAX_VERTICES+1];
  logic [VB-1:0] c_par   [MAX_VERTICES+1];
  logic [VB-1:0] c_child [MAX_VERTICES+1];

  logic [19:0]   w_clip;
  logic [20:0]   sum_wide;

  assign busy = (state_r != S_IDLE);

  always_comb begin
    if (nv_r == 5'd0) begin
      n_eff = NB'(1);
    end else if (32'(nv_r) > 32'(MAX_VERTICES)) begin
      n_eff = NB'(MAX_VERTICES);
    end else begin
      n_eff = NB'(nv_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nv_r <= pst_pkg::NV_RESET;
    end else if (cfg_we) begin
      nv_r <= cfg_wdata;
    end
  end

  assign load_ok = !busy && start && in_req_type == pst_pkg::REQ_LOAD &&
                   32'(in_row) < 32'(MAX_VERTICES) && 32'(in_col) < 32'(MAX_VERTICES);
  assign wr_data = WB'({16'd0, in_weight});
  assign vtx     = (state_r == S_DECIDE) ? c_child[MAX_VERTICES] : cur_r;

  assign c_vld[0]   = 1'b0;
  assign c_w[0]     = '0;
  assign c_rank[0]  = '0;
  assign c_par[0]   = '0;
  assign c_child[0] = '0;

  for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_cell
    pst_cell #(
      .MAX_V (MAX_VERTICES),
      .WB    (WB),
      .IDX   (i)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .vtx       (vtx),
      .rank      (rank_r),
      .n_act     (n_eff),
      .wr_en     (load_ok),
      .wr_row    (VB'(in_row)),
      .wr_col    (VB'(in_col)),
      .wr_data   (wr_data),
      .cin_vld   (c_vld[i]),
      .cin_w     (c_w[i]),
      .cin_rank  (c_rank[i]),
      .cin_par   (c_par[i]),
      .cin_child (c_child[i]),
      .cout_vld  (c_vld[i+1]),
      .cout_w    (c_w[i+1]),
      .cout_rank (c_rank[i+1]),
      .cout_par  (c_par[i+1]),
      .cout_child(c_child[i+1])
    );
  end

  always_comb begin
    if (33'(c_w[MAX_VERTICES]) > 33'(pst_pkg::SUM_MAX)) begin
      w_clip = pst_pkg::SUM_MAX;
    end else begin
      w_clip = 20'(c_w[MAX_VERTICES]);
    end
    sum_wide = 21'(sum_r) + 21'(w_clip);
  end

  always_comb begin
    state_nxt      = state_r;
    cur_nxt        = cur_r;
    rank_nxt       = rank_r;
    sweep_nxt      = sweep_r;
    edge_run_nxt   = edge_run_r;
    sum_nxt        = sum_r;
    ecnt_nxt       = ecnt_r;
    pend_par_nxt   = pend_par_r;
    pend_child_nxt = pend_child_r;
    ctrl           = '0;
    ov_nxt         = 1'b0;
    ost_nxt        = pst_pkg::ST_EDGE;
    opar_nxt       = '0;
    ochild_nxt     = '0;
    otw_nxt        = '0;
    olast_nxt      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          sum_nxt  = '0;
          ecnt_nxt = '0;
          rank_nxt = '0;
          if (in_req_type == pst_pkg::REQ_TOTAL) begin
            edge_run_nxt = 1'b0;
            cur_nxt      = '0;
            state_nxt    = S_INIT;
          end else if (in_req_type == pst_pkg::REQ_EDGES) begin
            if (32'(in_start_vertex) >= 32'(n_eff)) begin
              ov_nxt    = 1'b1;
              ost_nxt   = pst_pkg::ST_BAD_START;
              olast_nxt = 1'b1;
            end else begin
              edge_run_nxt = 1'b1;
              cur_nxt      = VB'(in_start_vertex);
              state_nxt    = S_INIT;
            end
          end
        end
      end
      S_INIT: begin
        ctrl.init = 1'b1;
        state_nxt = S_EXP;
      end
      S_READ: begin
        state_nxt = S_EXP;
      end
      S_EXP: begin
        ctrl.upd  = 1'b1;
        rank_nxt  = rank_r + VB'(1);
        sweep_nxt = '0;
        state_nxt = S_SWEEP;
      end
      S_SWEEP: begin
        sweep_nxt = sweep_r + VB'(1);
        if (sweep_r == SWEEP_LAST) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (c_vld[MAX_VERTICES]) begin
          ctrl.take = 1'b1;
          cur_nxt   = c_child[MAX_VERTICES];
          sum_nxt   = (sum_wide > 21'(pst_pkg::SUM_MAX)) ? pst_pkg::SUM_MAX
                                                        : sum_wide[19:0];
          if (edge_run_r && ecnt_r < pst_pkg::MAX_OUT) begin
            if (ecnt_r != 4'd0) begin
              ov_nxt     = 1'b1;
              ost_nxt    = pst_pkg::ST_EDGE;
              opar_nxt   = pend_par_r;
              ochild_nxt = pend_child_r;
            end
            pend_par_nxt   = 4'(c_par[MAX_VERTICES]);
            pend_child_nxt = 4'(c_child[MAX_VERTICES]);
            ecnt_nxt       = ecnt_r + 4'd1;
          end
          state_nxt = S_READ;
        end else begin
          ov_nxt    = 1'b1;
          olast_nxt = 1'b1;
          if (!edge_run_r) begin
            ost_nxt = pst_pkg::ST_TOTAL;
            otw_nxt = sum_r;
          end else if (ecnt_r == 4'd0) begin
            ost_nxt = pst_pkg::ST_NO_EDGES;
          end else begin
            ost_nxt    = pst_pkg::ST_EDGE;
            opar_nxt   = pend_par_r;
            ochild_nxt = pend_child_r;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_valid <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r             <= cur_nxt;
    rank_r            <= rank_nxt;
    sweep_r           <= sweep_nxt;
    edge_run_r        <= edge_run_nxt;
    sum_r             <= sum_nxt;
    ecnt_r            <= ecnt_nxt;
    pend_par_r        <= pend_par_nxt;
    pend_child_r      <= pend_child_nxt;
    out_status        <= ost_nxt;
    out_parent_vertex <= opar_nxt;
    out_child_vertex  <= ochild_nxt;
    out_total_weight  <= otw_nxt;
    out_last          <= olast_nxt;
  end

endmodule

[rtl/pst_chk.sv]
// Port-level checker for the spanning tree engine, bound to the top level.
// Depends on pst_pkg and prim_spanning_tree_engine_top.
module pst_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [1:0]  out_status,
  input logic [3:0]  out_parent_vertex,
  input logic [3:0]  out_child_vertex,
  input logic [19:0] out_total_weight,
  input logic        out_last
);

  // a transfer only follows a request or a running search
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy || start))
    else $error("result without request");

  a_nonedge_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != pst_pkg::ST_EDGE) |-> out_last)
    else $error("summary result not last");

  a_nonedge_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != pst_pkg::ST_EDGE) |->
      (out_parent_vertex == 4'd0 && out_child_vertex == 4'd0))
    else $error("vertex fields set on summary result");

  a_weight_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != pst_pkg::ST_TOTAL) |-> out_total_weight == 20'd0)
    else $error("weight set on non-total result");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last && out_status != pst_pkg::ST_BAD_START) |-> !busy)
    else $error("busy after final result");

endmodule

bind prim_spanning_tree_engine_top pst_chk u_pst_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_status       (out_status),
  .out_parent_vertex(out_parent_vertex),
  .out_child_vertex (out_child_vertex),
  .out_total_weight (out_total_weight),
  .out_last         (out_last)
);

[bench/testbench.sv]
// Testbench for prim_spanning_tree_engine_top: matrix loads and tree runs are checked
// against a built-in Prim predictor with a weight-sorted, arrival-stable edge queue.
// Depends on rtl/pst_pkg.sv and rtl/prim_spanning_tree_engine_top.sv.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REQ_SPARE = 2'd3;
  localparam int SETTLE = 60;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef enum logic [1:0] {K_ITEM, K_CFG, K_DRAIN} step_kind_t;

  typedef struct {
    step_kind_t  kind;
    logic [1:0]  req;
    logic [3:0]  row;
    logic [3:0]  col;
    logic [15:0] weight;
    logic [5:0]  sv;
    logic [4:0]  nv;
  } step_t;

  typedef struct {
    logic [1:0]  status;
    logic [3:0]  parent;
    logic [3:0]  child;
    logic [19:0] total;
    logic        last;
  } tree_res_t;

  typedef struct {
    logic [15:0] w;
    logic [3:0]  child;
    logic [3:0]  par;
  } hop_t;

  logic clk;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0]  in_req_type = '0;
  logic [3:0]  in_row = '0;
  logic [3:0]  in_col = '0;
  logic [15:0] in_weight = '0;
  logic [5:0]  in_start_vertex = '0;
  logic        cfg_we = 1'b0;
  logic [4:0]  cfg_wdata = '0;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [3:0]  out_parent_vertex;
  logic [3:0]  out_child_vertex;
  logic [19:0] out_total_weight;
  logic        out_last;

  prim_spanning_tree_engine_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req_type(in_req_type), .in_row(in_row), .in_col(in_col),
    .in_weight(in_weight), .in_start_vertex(in_start_vertex),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .out_valid(out_valid), .out_status(out_status),
    .out_parent_vertex(out_parent_vertex), .out_child_vertex(out_child_vertex),
    .out_total_weight(out_total_weight), .out_last(out_last)
  );

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  // predictor state
  logic [15:0] adj [16][16];
  logic [4:0]  nv_reg = pst_pkg::NV_RESET;
  tree_res_t   tree_expect [$];
  step_t       work [$];
  step_t       cur;
  int          mismatches = 0;
  int          accepted = 0;
  int          quiet = 0;
  int          stall = 0;

  initial begin
    for (int r = 0; r < 16; r++)
      for (int c = 0; c < 16; c++) adj[r][c] = '0;
  end

  function automatic int eff_n(logic [4:0] v);
    if (v == 0) return 1;
    if (v > 16) return 16;
    return int'(v);
  endfunction

  function automatic tree_res_t mk(logic [1:0] st, logic [3:0] p, logic [3:0] c,
                                   logic [19:0] tw, logic lst);
    tree_res_t r;
    r.status = st; r.parent = p; r.child = c; r.total = tw; r.last = lst;
    return r;
  endfunction

  // lazy Prim; appends tree edges to tree_expect when listing, returns edge count
  function automatic int grow_tree(int s, int n, bit listing, output logic [19:0] sum);
    hop_t q [$];
    hop_t e;
    bit   seen [16];
    int   pushes;
    int   edges;
    int   pos;
    int   v;
    sum = '0;
    pushes = 0;
    edges = 0;
    foreach (seen[i]) seen[i] = 0;
    v = s;
    seen[s] = 1;
    forever begin
      for (int i = 0; i < n; i++) begin
        if (adj[v][i] != 0 && pushes < 256) begin
          e.w = adj[v][i]; e.child = 4'(i); e.par = 4'(v);
          pos = 0;
          while (pos < q.size() && q[pos].w <= e.w) pos++;
          q.insert(pos, e);
          pushes++;
        end
      end
      v = -1;
      while (q.size() > 0 && v < 0) begin
        e = q.pop_front();
        if (!seen[e.child]) begin
          seen[e.child] = 1;
          if (32'(sum) + 32'(e.w) > 32'(pst_pkg::SUM_MAX)) sum = pst_pkg::SUM_MAX;
          else sum = sum + 20'(e.w);
          if (listing && edges < 15)
            tree_expect.push_back(mk(pst_pkg::ST_EDGE, e.par, e.child, '0, 1'b0));
          edges++;
          v = int'(e.child);
        end
      end
      if (v < 0) break;
    end
    return edges;
  endfunction

  function automatic void forecast(step_t it);
    int n;
    int cnt;
    logic [19:0] sum;
    tree_res_t r;
    n = eff_n(nv_reg);
    case (it.req)
      pst_pkg::REQ_LOAD: adj[it.row][it.col] = it.weight;
      pst_pkg::REQ_TOTAL: begin
        cnt = grow_tree(0, n, 0, sum);
        tree_expect.push_back(mk(pst_pkg::ST_TOTAL, '0, '0, sum, 1'b1));
      end
      pst_pkg::REQ_EDGES: begin
        if (it.sv >= n) tree_expect.push_back(mk(pst_pkg::ST_BAD_START, '0, '0, '0, 1'b1));
        else begin
          cnt = grow_tree(int'(it.sv), n, 1, sum);
          if (cnt == 0) tree_expect.push_back(mk(pst_pkg::ST_NO_EDGES, '0, '0, '0, 1'b1));
          else begin
            r = tree_expect.pop_back();
            r.last = 1;
            tree_expect.push_back(r);
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void add_item(logic [1:0] req, logic [3:0] row, logic [3:0] col,
                                   logic [15:0] w, logic [5:0] sv);
    step_t s;
    s.kind = K_ITEM; s.req = req; s.row = row; s.col = col; s.weight = w; s.sv = sv;
    s.nv = '0;
    work.push_back(s);
  endfunction

  function automatic void add_marker(step_kind_t k, logic [4:0] v);
    step_t s;
    s = '{kind: k, req: REQ_SPARE, row: 0, col: 0, weight: 0, sv: 0, nv: v};
    work.push_back(s);
  endfunction

  function automatic logic [15:0] pick_weight();
    int d;
    d = $urandom_range(0, 99);
    if (d < 40) return 16'($urandom_range(1, 6));
    if (d < 50) return '0;
    return 16'($urandom);
  endfunction

  function automatic void random_phase(logic [4:0] nvv, int items);
    int n;
    int d;
    logic [3:0] a;
    logic [3:0] b;
    logic [15:0] w;
    n = eff_n(nvv);
    // build a mostly symmetric graph first so runs reach deep
    for (int i = 0; i < n; i++) begin
      a = 4'($urandom_range(0, n - 1));
      b = 4'($urandom_range(0, n - 1));
      w = pick_weight();
      add_item(pst_pkg::REQ_LOAD, a, b, w, 6'($urandom));
      if ($urandom_range(0, 9) < 8) add_item(pst_pkg::REQ_LOAD, b, a, w, 6'($urandom));
    end
    for (int i = 0; i < items; i++) begin
      d = $urandom_range(0, 99);
      if (d < 62) begin
        a = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(0, n - 1));
        b = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(0, n - 1));
        add_item(pst_pkg::REQ_LOAD, a, b, pick_weight(), 6'($urandom));
      end else if (d < 78) begin
        add_item(pst_pkg::REQ_TOTAL, 4'($urandom), 4'($urandom), 16'($urandom),
                 6'($urandom));
      end else if (d < 97) begin
        add_item(pst_pkg::REQ_EDGES, 4'($urandom), 4'($urandom), 16'($urandom),
                 ($urandom_range(0, 6) == 0) ? 6'($urandom) : 6'($urandom_range(0, n - 1)));
      end else begin
        add_item(REQ_SPARE, 4'($urandom), 4'($urandom), 16'($urandom), 6'($urandom));
      end
    end
  endfunction

  // driver
  always @(posedge clk) begin
    bit go;
    bit we;
    logic [4:0] wd;
    go = start;
    we = 0;
    wd = cfg_wdata;
    if (!rst_n) begin
      go = 0;
    end else begin
      if (start && !busy) begin
        forecast(cur);
        accepted++;
        go = 0;
      end
      if (!go && work.size() > 0) begin
        case (work[0].kind)
          K_ITEM: begin
            if ((accepted >= 150 && accepted < 260) || $urandom_range(0, 99) >= 32) begin
              cur = work.pop_front();
              go = 1;
            end
          end
          K_CFG: begin
            if (tree_expect.size() == 0 && quiet >= SETTLE) begin
              wd = work[0].nv;
              nv_reg = wd;
              we = 1;
              void'(work.pop_front());
            end
          end
          default: if (tree_expect.size() == 0) void'(work.pop_front());
        endcase
      end
    end
    quiet = (busy || start || we || tree_expect.size() != 0) ? 0 : quiet + 1;
    start <= go;
    in_req_type <= cur.req;
    in_row <= cur.row;
    in_col <= cur.col;
    in_weight <= cur.weight;
    in_start_vertex <= cur.sv;
    cfg_we <= we;
    cfg_wdata <= wd;
  end

  // monitor
  always @(posedge clk) begin
    tree_res_t x;
    if (rst_n && out_valid) begin
      if (tree_expect.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transfer: status %0d parent %0d child %0d total %0d last %0d",
                   out_status, out_parent_vertex, out_child_vertex, out_total_weight, out_last);
      end else begin
        x = tree_expect.pop_front();
        if (out_status !== x.status || out_parent_vertex !== x.parent ||
            out_child_vertex !== x.child || out_total_weight !== x.total ||
            out_last !== x.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp st %0d p %0d c %0d tw %0d l %0d, ",
                      "got st %0d p %0d c %0d tw %0d l %0d"},
                     x.status, x.parent, x.child, x.total, x.last, out_status,
                     out_parent_vertex, out_child_vertex, out_total_weight, out_last);
        end
      end
    end
  end

  // watchdog: cycles with no transfer on either side
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || cfg_we) stall <= 0;
    else stall <= stall + 1;
    if (stall >= WATCHDOG_LIMIT) begin
      $display("prim_spanning_tree_engine_top test failed");
      $finish;
    end
  end

  initial begin
    cur = '{kind: K_ITEM, req: REQ_SPARE, row: 0, col: 0, weight: 0, sv: 0, nv: 0};
    // directed: empty matrix, extremes, every request and special case
    add_item(pst_pkg::REQ_TOTAL, 0, 0, 0, 0);
    add_item(pst_pkg::REQ_EDGES, 0, 0, 0, 0);
    add_item(pst_pkg::REQ_EDGES, 0, 0, 0, 6'd16);
    add_item(pst_pkg::REQ_EDGES, 0, 0, 0, 6'd63);
    add_item(pst_pkg::REQ_LOAD, 4'd0, 4'd15, 16'hFFFF, 0);
    add_item(pst_pkg::REQ_LOAD, 4'd15, 4'd0, 16'hFFFF, 0);
    add_item(pst_pkg::REQ_LOAD, 4'd15, 4'd15, 16'd7, 0);
    add_item(pst_pkg::REQ_LOAD, 4'd0, 4'd1, 16'd3, 0);
    add_item(pst_pkg::REQ_LOAD, 4'd1, 4'd0, 16'd3, 0);
    add_item(pst_pkg::REQ_LOAD, 4'd1, 4'd2, 16'd3, 0);
    add_item(pst_pkg::REQ_LOAD, 4'd2, 4'd1, 16'd3, 0);
    add_item(pst_pkg::REQ_LOAD, 4'd0, 4'd2, 16'd3, 0);
    add_item(pst_pkg::REQ_TOTAL, 0, 0, 0, 0);
    add_item(pst_pkg::REQ_EDGES, 0, 0, 0, 6'd15);
    add_item(pst_pkg::REQ_EDGES, 0, 0, 0, 6'd2);
    add_item(pst_pkg::REQ_EDGES, 0, 0, 0, 6'd7);
    add_item(REQ_SPARE, 4'd15, 4'd15, 16'hFFFF, 6'd63);
    add_item(pst_pkg::REQ_LOAD, 4'd0, 4'd15, 16'd0, 0);
    add_item(pst_pkg::REQ_EDGES, 0, 0, 0, 6'd15);
    add_item(pst_pkg::REQ_TOTAL, 0, 0, 0, 0);
    add_marker(K_CFG, 5'd1);
    add_item(pst_pkg::REQ_TOTAL, 0, 0, 0, 0);
    add_item(pst_pkg::REQ_EDGES, 0, 0, 0, 6'd0);
    add_item(pst_pkg::REQ_EDGES, 0, 0, 0, 6'd1);
    // random phases across vertex counts, extremes included
    add_marker(K_CFG, 5'd5);
    random_phase(5'd5, 30);
    add_marker(K_CFG, 5'd16);
    random_phase(5'd16, 40);
    add_marker(K_DRAIN, 0);
    random_phase(5'd16, 30);
    add_marker(K_CFG, 5'd3);
    random_phase(5'd3, 40);
    add_marker(K_CFG, 5'd31);
    random_phase(5'd31, 40);
    add_marker(K_CFG, 5'd0);
    random_phase(5'd0, 15);
    add_marker(K_CFG, 5'd8);
    random_phase(5'd8, 40);
    add_marker(K_CFG, 5'd12);
    random_phase(5'd12, 30);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    while (work.size() != 0 || start) @(posedge clk);
    while (tree_expect.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && tree_expect.size() == 0)
      $display("prim_spanning_tree_engine_top test passed");
    else
      $display("prim_spanning_tree_engine_top test failed");
    $finish;
  end

endmodule
